FILE: rtl/i2r_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// i2r_pkg: shared types and tables for the integer to roman encoder
// Numeral table (weights and letters), ascii codes, fsm state and the
// command / status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package i2r_pkg;

  localparam int NUM_W   = 12;
  localparam int SYM_W   = 7;
  localparam int ENTRIES = 13;
  localparam int IDX_W   = 4;

  localparam logic [NUM_W-1:0] MAX_VALID = 12'd3999;

  // ascii codes of the numeral letters
  localparam logic [SYM_W-1:0] CH_NONE = 7'h00;
  localparam logic [SYM_W-1:0] CH_I    = 7'h49;
  localparam logic [SYM_W-1:0] CH_V    = 7'h56;
  localparam logic [SYM_W-1:0] CH_X    = 7'h58;
  localparam logic [SYM_W-1:0] CH_L    = 7'h4C;
  localparam logic [SYM_W-1:0] CH_C    = 7'h43;
  localparam logic [SYM_W-1:0] CH_D    = 7'h44;
  localparam logic [SYM_W-1:0] CH_M    = 7'h4D;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [NUM_W-1:0] num_t;
  typedef logic [SYM_W-1:0] sym_t;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_RUN
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic step;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_free;
    logic step_last;
  } status_t;

  // weight of each table entry, descending
  function automatic num_t weight(input idx_t i);
    num_t w;
    case (i)
      4'd0:    w = 12'd1000;
      4'd1:    w = 12'd900;
      4'd2:    w = 12'd500;
      4'd3:    w = 12'd400;
      4'd4:    w = 12'd100;
      4'd5:    w = 12'd90;
      4'd6:    w = 12'd50;
      4'd7:    w = 12'd40;
      4'd8:    w = 12'd10;
      4'd9:    w = 12'd9;
      4'd10:   w = 12'd5;
      4'd11:   w = 12'd4;
      default: w = 12'd1;
    endcase
    return w;
  endfunction

  // first letter of each entry
  function automatic sym_t letter_a(input idx_t i);
    sym_t s;
    case (i)
      4'd0:    s = CH_M;
      4'd1:    s = CH_C;
      4'd2:    s = CH_D;
      4'd3:    s = CH_C;
      4'd4:    s = CH_C;
      4'd5:    s = CH_X;
      4'd6:    s = CH_L;
      4'd7:    s = CH_X;
      4'd8:    s = CH_X;
      4'd9:    s = CH_I;
      4'd10:   s = CH_V;
      4'd11:   s = CH_I;
      default: s = CH_I;
    endcase
    return s;
  endfunction

  // second letter of subtractive entries, none otherwise
  function automatic sym_t letter_b(input idx_t i);
    sym_t s;
    case (i)
      4'd1:    s = CH_M;
      4'd3:    s = CH_D;
      4'd5:    s = CH_C;
      4'd7:    s = CH_L;
      4'd9:    s = CH_X;
      4'd11:   s = CH_V;
      default: s = CH_NONE;
    endcase
    return s;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/i2r_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// i2r_ctrl: conversion sequencer
// Takes a number when idle, then steps the datapath one letter per cycle
// whenever the output register is free, until the final letter is issued.
// ----------------------------------------------------------------------------
module i2r_ctrl (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              in_tvalid,
  output logic             in_tready,
  input  i2r_pkg::status_t status,
  output i2r_pkg::cmd_t    cmd
);
  import i2r_pkg::*;

  state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if (status.out_free) begin
          cmd.step = 1'b1;
          if (status.step_last) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

FILE: rtl/i2r_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// i2r_datapath: remainder, table lookup and output register
// Picks the largest table weight not above the remainder, issues its
// letters one per step and subtracts the weight.
// ----------------------------------------------------------------------------
module i2r_datapath (
  input  wire                   clk,
  input  wire                   rst_n,
  input  i2r_pkg::cmd_t         cmd,
  output i2r_pkg::status_t      status,
  input  wire [i2r_pkg::NUM_W-1:0] number,
  output logic                  out_valid,
  input  wire                   out_ready,
  output logic [i2r_pkg::SYM_W-1:0] out_symbol,
  output logic                  out_last,
  output logic                  out_invalid
);
  import i2r_pkg::*;

  num_t rest_r, rest_nxt;
  idx_t sel_r, sel_nxt;
  logic second_r, second_nxt;
  logic invalid_r, invalid_nxt;
  logic out_valid_r, out_valid_nxt;
  sym_t sym_r;
  logic last_r, inv_r;

  idx_t sel;
  num_t rest_sub;
  sym_t step_sym;
  logic step_last;

  // largest weight not above the remainder
  always_comb begin
    sel = idx_t'(ENTRIES - 1);
    for (int k = ENTRIES - 1; k >= 0; k--) begin
      if (rest_r >= weight(idx_t'(k))) begin
        sel = idx_t'(k);
      end
    end
  end

  // letter produced by one step
  always_comb begin
    rest_sub  = rest_r - weight(sel);
    step_sym  = letter_a(sel);
    step_last = 1'b0;
    if (invalid_r) begin
      step_sym  = CH_NONE;
      step_last = 1'b1;
    end else if (second_r) begin
      step_sym  = letter_b(sel_r);
      step_last = (rest_r == '0);
    end else begin
      step_last = (letter_b(sel) == CH_NONE) && (rest_sub == '0);
    end
  end

  // working register updates
  always_comb begin
    rest_nxt    = rest_r;
    sel_nxt     = sel_r;
    second_nxt  = second_r;
    invalid_nxt = invalid_r;
    if (cmd.load) begin
      rest_nxt    = number;
      invalid_nxt = (number == '0) || (number > MAX_VALID);
      second_nxt  = 1'b0;
    end else if (cmd.step && !invalid_r) begin
      if (second_r) begin
        second_nxt = 1'b0;
      end else begin
        rest_nxt   = rest_sub;
        sel_nxt    = sel;
        second_nxt = (letter_b(sel) != CH_NONE);
      end
    end
  end

  // output register occupancy
  always_comb begin
    if (cmd.step) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // control flops
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      second_r    <= 1'b0;
      invalid_r   <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      second_r    <= second_nxt;
      invalid_r   <= invalid_nxt;
    end
  end

  // payload flops
  always_ff @(posedge clk) begin
    rest_r <= rest_nxt;
    sel_r  <= sel_nxt;
    if (cmd.step) begin
      sym_r  <= step_sym;
      last_r <= step_last;
      inv_r  <= invalid_r;
    end
  end

  assign status.out_free  = !out_valid_r || out_ready;
  assign status.step_last = step_last;
  assign out_valid        = out_valid_r;
  assign out_symbol       = sym_r;
  assign out_last         = last_r;
  assign out_invalid      = inv_r;

endmodule
`default_nettype wire

FILE: rtl/integer_to_roman_encoder_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// integer_to_roman_encoder_top: integer to roman numeral encoder
// Converts 1..3999 to a run of ascii letters, most significant first, with
// tlast on the final letter; 0 and values above 3999 give one invalid result.
//
//   channel | direction | contents
//   in_     | slave     | tdata[11:0] number
//   out_    | master    | tdata[6:0] symbol, tlast last, tuser invalid
//
// Within a number one letter leaves per cycle while out_tready is high; a number
// gives as many letters as its numeral has (1 to 15), after its load step.
// A new number is taken once the last letter of the previous one is in the
// output register, while that letter still waits to be taken.
// out_tready low holds the output register and pauses the conversion.
// Reset (rst_n low, synchronous) returns to idle with no pending result.
// ----------------------------------------------------------------------------
module integer_to_roman_encoder_top (
  input  wire        clk,
  input  wire        rst_n,
  input  wire        in_tvalid,
  output logic       in_tready,
  input  wire [15:0] in_tdata,   // [11:0] number, [15:12] zero
  output logic       out_tvalid,
  input  wire        out_tready,
  output logic [7:0] out_tdata,  // [6:0] symbol, [7] zero
  output logic       out_tlast,
  output logic       out_tuser   // [0] invalid
);
  import i2r_pkg::*;

  cmd_t    cmd;
  status_t status;
  sym_t    symbol;

  // sequencer
  i2r_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .status    (status),
    .cmd       (cmd)
  );

  // remainder, lookup and output register
  i2r_datapath u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .status      (status),
    .number      (in_tdata[NUM_W-1:0]),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_symbol  (symbol),
    .out_last    (out_tlast),
    .out_invalid (out_tuser)
  );

  assign out_tdata = {1'b0, symbol};

endmodule
`default_nettype wire

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the integer to roman encoder
// Sends a directed set of numbers followed by random ones over the input
// stream. A scoreboard predicts each letter run digit by digit and checks
// every output transaction in order. Sender bursts and receiver stalls are
// randomized.
// ----------------------------------------------------------------------------
module tb_top;
  import i2r_pkg::*;

  localparam int RANDOM_ITEMS = 135;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 24;

  // one expected output letter
  typedef struct packed {
    sym_t symbol;
    logic last;
    logic invalid;
  } letter_t;

  // expected letter runs, checked in arrival order
  class encoder_scoreboard;
    letter_t letter_q[$];
    int      errors = 0;

    task report(input string msg);
      $display("ERROR at %0t: %s", $time, msg);
      errors++;
    endtask

    // predict the numeral for one accepted number, one decade at a time
    function void note_number(input num_t num);
      sym_t        run[$];
      sym_t        one, five, ten;
      int unsigned digit;
      int unsigned scale;
      letter_t     e;
      if (num == 0 || num > 3999) begin
        e.symbol  = CH_NONE;
        e.last    = 1'b1;
        e.invalid = 1'b1;
        letter_q.push_back(e);
        return;
      end
      scale = 1000;
      for (int d = 3; d >= 0; d--) begin
        case (d)
          3: begin one = CH_M; five = CH_NONE; ten = CH_NONE; end
          2: begin one = CH_C; five = CH_D;    ten = CH_M;    end
          1: begin one = CH_X; five = CH_L;    ten = CH_C;    end
          default: begin one = CH_I; five = CH_V; ten = CH_X; end
        endcase
        digit = (int'(num) / scale) % 10;
        scale = scale / 10;
        if (digit == 9) begin
          run.push_back(one);
          run.push_back(ten);
        end else if (digit == 4) begin
          run.push_back(one);
          run.push_back(five);
        end else begin
          if (digit >= 5) begin
            run.push_back(five);
            digit -= 5;
          end
          repeat (digit) run.push_back(one);
        end
      end
      foreach (run[i]) begin
        e.symbol  = run[i];
        e.last    = (i == run.size() - 1);
        e.invalid = 1'b0;
        letter_q.push_back(e);
      end
    endfunction

    // compare one output transaction with the oldest expected letter
    task check_letter(input sym_t symbol, input logic last, input logic invalid);
      letter_t e;
      if (letter_q.size() == 0) begin
        report($sformatf("unexpected letter %h last %b invalid %b",
                         symbol, last, invalid));
        return;
      end
      e = letter_q.pop_front();
      if (symbol !== e.symbol)
        report($sformatf("symbol %h, want %h", symbol, e.symbol));
      if (last !== e.last)
        report($sformatf("last %b, want %b", last, e.last));
      if (invalid !== e.invalid)
        report($sformatf("invalid %b, want %b", invalid, e.invalid));
    endtask

    function int pending();
      return letter_q.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;   // [11:0] number, [15:12] zero
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;       // [6:0] symbol, [7] zero
  logic        out_tlast;
  logic        out_tuser;       // [0] invalid

  encoder_scoreboard sb = new();

  int unsigned burst_left = 0;
  int unsigned stall_mode = 0;
  int unsigned stall_left = 0;
  int unsigned ready_phase = 0;
  int          cycle_count = 0;

  integer_to_roman_encoder_top i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  // 12 ns clock
  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // run watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  // receiver stall pattern, switching among four random styles
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(20, 80);
    end else begin
      stall_left--;
    end
    ready_phase++;
    case (stall_mode)
      0:       out_tready <= 1'b1;
      1:       out_tready <= 1'($urandom_range(0, 1));
      2:       out_tready <= (ready_phase % 4) != 3;
      default: out_tready <= ($urandom_range(0, 4) == 0);
    endcase
  end

  // output monitor
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      sb.check_letter(out_tdata[6:0], out_tlast, out_tuser);
  end

  // drive one number, with a random gap at the start of each burst
  task automatic send_number(input num_t num);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
      if (gap > 0) begin
        @(negedge clk);
        in_tvalid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= {4'b0000, num};
    do @(posedge clk); while (!in_tready);
    sb.note_number(num);
  endtask

  initial begin
    num_t directed_nums[] = '{
      12'd1, 12'd3999, 12'd0, 12'd4000, 12'd4095, 12'd3888, 12'd4, 12'd9,
      12'd40, 12'd90, 12'd400, 12'd900, 12'd5, 12'd50, 12'd500, 12'd1000,
      12'd3, 12'd2024, 12'd1994, 12'd444, 12'd999, 12'd14, 12'd2048,
      12'd1365, 12'd2730
    };
    num_t num;

    // reset
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    // extremes, table weights other than 100 and 10, out of range values
    foreach (directed_nums[i]) send_number(directed_nums[i]);

    // random numbers, mostly in range
    repeat (RANDOM_ITEMS) begin
      case ($urandom_range(0, 19))
        0:       num = 12'd0;
        1, 2:    num = num_t'($urandom_range(4000, 4095));
        3:       num = num_t'($urandom_range(3000, 3999));
        default: num = num_t'($urandom_range(1, 3999));
      endcase
      send_number(num);
    end
    @(negedge clk);
    in_tvalid <= 1'b0;

    // drain
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.errors == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/i2r_pkg.sv
rtl/i2r_ctrl.sv
rtl/i2r_datapath.sv
rtl/integer_to_roman_encoder_top.sv
tb/tb_top.sv
